// ----- design/thp_pkg.sv -----
// ---------------------------------------------------------------------------
// thp_pkg : shared types, constants and helpers for sensor compensation
// Transfer types, calibration bundle, register indexes and the arithmetic
// shift and sign-extension helpers used across the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package thp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_TEMP         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_PRESS_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_PRESS_MIDDLE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_PRESS_LAST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_HUM_FIRST    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_HUM_LAST     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_PRECISION  = 3'd6;
    localparam int unsigned CFG_DATA_W = 48;

    // Queue between front and back (depth is a power of two)
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // One raw reading
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    // One compensated result
    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic               pressure_divisor_zero;
    } result_t;

    // Calibration register bundle
    typedef struct packed {
        logic [47:0] cal_temp;
        logic [47:0] cal_press_first;
        logic [47:0] cal_press_middle;
        logic [47:0] cal_press_last;
        logic [31:0] cal_hum_first;
        logic [31:0] cal_hum_last;
        logic        pressure_precision;
    } cal_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic    valid;
        logic    wide_path;
        sample_t sample;
    } queue_head_t;

    // Queue entry: reading plus its pressure path class
    typedef struct packed {
        logic    wide_path;
        sample_t sample;
    } queue_entry_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx12(input logic [11:0] v);
        sx12 = {{52{v[11]}}, v};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] v);
        sx8 = {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
        asr64 = $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        asr32 = $unsigned($signed(v) >>> n);
    endfunction

endpackage

`default_nettype wire

// ----- design/thp_front.sv -----
// ---------------------------------------------------------------------------
// thp_front : reading intake and queue
// Takes readings on the command port, tags each with its pressure path and
// holds them in a short queue until the back end is free.
// ---------------------------------------------------------------------------
`default_nettype none

module thp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire thp_pkg::sample_t     sample,
    input  wire logic                 wide_path,
    input  wire logic                 pop,
    output thp_pkg::queue_head_t      head
);

    thp_pkg::queue_entry_t          q_mem [thp_pkg::QUEUE_DEPTH];
    logic [thp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [thp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [thp_pkg::QPTR_W:0]       count_reg, count_next;
    logic                           push;

    // Accept while there is room
    assign busy = (count_reg == (thp_pkg::QPTR_W+1)'(thp_pkg::QUEUE_DEPTH));
    assign push = start && !busy;

    // Present the oldest entry
    assign head.valid     = (count_reg != '0);
    assign head.wide_path = q_mem[rd_ptr_reg].wide_path;
    assign head.sample    = q_mem[rd_ptr_reg].sample;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the transfer with its class
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].sample    <= sample;
            q_mem[wr_ptr_reg].wide_path <= wide_path;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (thp_pkg::QPTR_W+1)'(thp_pkg::QUEUE_DEPTH))
        else $error("queue fill count exceeds depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop without push did not drain the queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- design/thp_mul.sv -----
// ---------------------------------------------------------------------------
// thp_mul : shared wrapping 64-bit multiplier
// Forms the low 64 bits of a 64 by 64 product from three 32 by 32 partial
// products, one per cycle, accumulated in a register.
// ---------------------------------------------------------------------------
`default_nettype none

module thp_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      product
);

    localparam logic [1:0] PP_IDLE = 2'd0;
    localparam logic [1:0] PP_LL   = 2'd1;
    localparam logic [1:0] PP_LH   = 2'd2;
    localparam logic [1:0] PP_HL   = 2'd3;

    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        done_reg;
    logic [31:0] op_x, op_y;
    logic [63:0] part;

    // Select the partial product of this cycle
    always_comb
    begin
        unique case (cnt_reg)
            PP_LL:   begin op_x = a_reg[31:0];  op_y = b_reg[31:0];  end
            PP_LH:   begin op_x = a_reg[31:0];  op_y = b_reg[63:32]; end
            PP_HL:   begin op_x = a_reg[63:32]; op_y = b_reg[31:0];  end
            default: begin op_x = '0;           op_y = '0;           end
        endcase
    end

    assign part = {32'b0, op_x} * {32'b0, op_y};

    // Accumulate and advance
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        unique case (cnt_reg)
            PP_LL:   begin acc_next = part; cnt_next = PP_LH; end
            PP_LH:   begin acc_next = acc_reg + {part[31:0], 32'b0}; cnt_next = PP_HL; end
            PP_HL:   begin acc_next = acc_reg + {part[31:0], 32'b0}; cnt_next = PP_IDLE; end
            default: if (start) cnt_next = PP_LL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= PP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= (cnt_reg == PP_HL);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && cnt_reg == PP_IDLE)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ----- design/thp_div.sv -----
// ---------------------------------------------------------------------------
// thp_div : radix-2 signed 64-bit divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero and wrapped to 64 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module thp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quot
);

    logic [63:0] dvd_reg, dsr_reg, rem_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] shifted;
    logic [64:0] trial;

    // Shift in the next dividend bit and try a subtract
    assign shifted = {rem_reg[62:0], dvd_reg[63]};
    assign trial   = {1'b0, shifted} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 7'd1);
            if (start)
            begin
                cnt_reg <= 7'd64;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63] ^ den[63];
            dvd_reg <= num[63] ? (64'd0 - num) : num;
            dsr_reg <= den[63] ? (64'd0 - den) : den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                dvd_reg <= {dvd_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                dvd_reg <= {dvd_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (64'd0 - dvd_reg) : dvd_reg;

endmodule

`default_nettype wire

// ----- design/thp_back.sv -----
// ---------------------------------------------------------------------------
// thp_back : compensation sequencer
// Steps one reading through temperature, pressure and humidity formulas on
// the shared multiplier and divider, then issues one result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module thp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire thp_pkg::cal_t        cal,
    input  wire thp_pkg::queue_head_t head,
    output logic                      pop,
    output logic                      result_valid,
    output thp_pkg::result_t          result
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ISSUE = 4'b0010,
        PH_MULW  = 4'b0100,
        PH_DIVW  = 4'b1000
    } phase_t;

    localparam logic [5:0] ST_T0 = 6'd0,  ST_T1 = 6'd1,  ST_T2 = 6'd2,  ST_T3 = 6'd3;
    localparam logic [5:0] ST_P0 = 6'd4,  ST_P1 = 6'd5,  ST_P2 = 6'd6,  ST_P3 = 6'd7;
    localparam logic [5:0] ST_P4 = 6'd8,  ST_P5 = 6'd9,  ST_P6 = 6'd10, ST_P7 = 6'd11;
    localparam logic [5:0] ST_P8 = 6'd12, ST_P9 = 6'd13, ST_PF = 6'd14;
    localparam logic [5:0] ST_Q0 = 6'd15, ST_Q1 = 6'd16, ST_Q2 = 6'd17, ST_Q3 = 6'd18;
    localparam logic [5:0] ST_Q4 = 6'd19, ST_Q5 = 6'd20, ST_Q6 = 6'd21, ST_Q7 = 6'd22;
    localparam logic [5:0] ST_Q8 = 6'd23, ST_Q9 = 6'd24, ST_QF = 6'd25, ST_DV = 6'd26;
    localparam logic [5:0] ST_H0 = 6'd27, ST_H1 = 6'd28, ST_H2 = 6'd29, ST_H3 = 6'd30;
    localparam logic [5:0] ST_H4 = 6'd31, ST_H5 = 6'd32, ST_H6 = 6'd33, ST_H7 = 6'd34;

    phase_t            phase_reg, phase_next;
    logic [5:0]        step_reg, step_next;
    thp_pkg::sample_t  item_reg, item_next;
    logic              wide_reg, wide_next;
    logic [63:0]       rt_reg, rt_next, ra_reg, ra_next, rb_reg, rb_next;
    logic [63:0]       rc_reg, rc_next, rs_reg, rs_next, rp_reg, rp_next;
    logic [23:0]       temp_reg, temp_next;
    logic [31:0]       press_reg, press_next;
    logic              zero_reg, zero_next;
    logic              result_valid_reg, result_valid_next;
    thp_pkg::result_t  result_reg, result_next;

    logic              mul_start, mul_done, div_start, div_done;
    logic [63:0]       mul_a, mul_b, mul_p, div_num, div_q;

    // Calibration coefficients, extended to 64 bits
    logic [63:0] c_t1, c_t2, c_t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6;

    assign c_t1 = {48'b0, cal.cal_temp[15:0]};
    assign c_t2 = thp_pkg::sx16(cal.cal_temp[31:16]);
    assign c_t3 = thp_pkg::sx16(cal.cal_temp[47:32]);
    assign p1   = {48'b0, cal.cal_press_first[15:0]};
    assign p2   = thp_pkg::sx16(cal.cal_press_first[31:16]);
    assign p3   = thp_pkg::sx16(cal.cal_press_first[47:32]);
    assign p4   = thp_pkg::sx16(cal.cal_press_middle[15:0]);
    assign p5   = thp_pkg::sx16(cal.cal_press_middle[31:16]);
    assign p6   = thp_pkg::sx16(cal.cal_press_middle[47:32]);
    assign p7   = thp_pkg::sx16(cal.cal_press_last[15:0]);
    assign p8   = thp_pkg::sx16(cal.cal_press_last[31:16]);
    assign p9   = thp_pkg::sx16(cal.cal_press_last[47:32]);
    assign h1   = {56'b0, cal.cal_hum_first[7:0]};
    assign h2   = thp_pkg::sx16(cal.cal_hum_first[23:8]);
    assign h3   = {56'b0, cal.cal_hum_first[31:24]};
    assign h4   = thp_pkg::sx12(cal.cal_hum_last[11:0]);
    assign h5   = thp_pkg::sx12(cal.cal_hum_last[23:12]);
    assign h6   = thp_pkg::sx8(cal.cal_hum_last[31:24]);

    // Intermediate terms
    logic [63:0] ut64, up64, d64, a64, pp64, x64, tc, pf64, a_new64;
    logic [31:0] pr32, a32, q32, v32h, s32, qf32, a_new32, hv32, hcl32;
    logic [23:0] temp_sat;

    assign ut64    = {44'b0, item_reg.raw_temperature};
    assign up64    = {44'b0, item_reg.raw_pressure};
    assign d64     = (ut64 >> 4) - c_t1;
    assign a64     = rt_reg - 64'd128000;
    assign pp64    = 64'd1048576 - up64;
    assign x64     = thp_pkg::asr64(rp_reg, 13);
    assign pr32    = mul_p[31:0];
    assign a32     = thp_pkg::asr32(rt_reg[31:0], 1) - 32'd64000;
    assign q32     = thp_pkg::asr32(a32, 2);
    assign v32h    = rt_reg[31:0] - 32'd76800;
    assign s32     = thp_pkg::asr32(ra_reg[31:0], 15);
    assign a_new64 = thp_pkg::asr64(mul_p, 33);
    assign a_new32 = thp_pkg::asr32(pr32, 15);

    // Round and saturate temperature
    assign tc = thp_pkg::asr64(mul_p + 64'd128, 8);
    always_comb
    begin
        priority if ($signed(tc) > 64'sd8388607)
        begin
            temp_sat = 24'h7FFFFF;
        end
        else if ($signed(tc) < -64'sd8388608)
        begin
            temp_sat = 24'h800000;
        end
        else
        begin
            temp_sat = tc[23:0];
        end
    end

    // Final pressure terms for both paths
    assign pf64 = thp_pkg::asr64(rp_reg + ra_reg + rb_reg, 8) + (p7 << 4);
    assign qf32 = rp_reg[31:0]
                + thp_pkg::asr32(ra_reg[31:0] + rb_reg[31:0] + p7[31:0], 4);

    // Clamp humidity to 0 .. 100 %
    assign hv32 = ra_reg[31:0] - thp_pkg::asr32(pr32, 4);
    always_comb
    begin
        priority if (hv32[31])
        begin
            hcl32 = '0;
        end
        else if (hv32 > 32'd419430400)
        begin
            hcl32 = 32'd419430400;
        end
        else
        begin
            hcl32 = hv32;
        end
    end

    // Dividend: the narrow path pre-shifts when the value leaves room
    always_comb
    begin
        if (wide_reg)
        begin
            div_num = rc_reg;
        end
        else if (rc_reg[31])
        begin
            div_num = {32'b0, rc_reg[31:0]};
        end
        else
        begin
            div_num = {31'b0, rc_reg[31:0], 1'b0};
        end
    end

    // Multiplier operands per step
    always_comb
    begin
        unique case (step_reg)
            ST_T0: begin mul_a = (ut64 >> 3) - (c_t1 << 1); mul_b = c_t2; end
            ST_T1: begin mul_a = d64;    mul_b = d64;    end
            ST_T2: begin mul_a = rb_reg; mul_b = c_t3;   end
            ST_T3: begin mul_a = rt_reg; mul_b = 64'd5;  end
            ST_P0: begin mul_a = a64;    mul_b = a64;    end
            ST_P1: begin mul_a = rs_reg; mul_b = p6;     end
            ST_P2: begin mul_a = ra_reg; mul_b = p5;     end
            ST_P3: begin mul_a = rs_reg; mul_b = p3;     end
            ST_P4: begin mul_a = ra_reg; mul_b = p2;     end
            ST_P5: begin mul_a = 64'h0000_8000_0000_0000 + rc_reg; mul_b = p1; end
            ST_P6: begin mul_a = (pp64 << 31) - rb_reg; mul_b = 64'd3125; end
            ST_P7: begin mul_a = x64;    mul_b = x64;    end
            ST_P8: begin mul_a = rs_reg; mul_b = p9;     end
            ST_P9: begin mul_a = p8;     mul_b = rp_reg; end
            ST_Q0: begin mul_a = {32'b0, q32}; mul_b = {32'b0, q32}; end
            ST_Q1:
            begin
                mul_a = {32'b0, thp_pkg::asr32(rs_reg[31:0], 11)};
                mul_b = p6;
            end
            ST_Q2: begin mul_a = ra_reg; mul_b = p5; end
            ST_Q3:
            begin
                mul_a = p3;
                mul_b = {32'b0, thp_pkg::asr32(rs_reg[31:0], 13)};
            end
            ST_Q4: begin mul_a = p2; mul_b = ra_reg; end
            ST_Q5: begin mul_a = {32'b0, 32'd32768 + rc_reg[31:0]}; mul_b = p1; end
            ST_Q6:
            begin
                mul_a = {32'b0, 32'd1048576 - {12'b0, item_reg.raw_pressure}
                         - thp_pkg::asr32(rb_reg[31:0], 12)};
                mul_b = 64'd3125;
            end
            ST_Q7: begin mul_a = {35'b0, rp_reg[31:3]}; mul_b = {35'b0, rp_reg[31:3]}; end
            ST_Q8: begin mul_a = p9; mul_b = rs_reg; end
            ST_Q9: begin mul_a = {34'b0, rp_reg[31:2]}; mul_b = p8; end
            ST_H0: begin mul_a = h5;     mul_b = {32'b0, v32h}; end
            ST_H1: begin mul_a = ra_reg; mul_b = h6;     end
            ST_H2: begin mul_a = ra_reg; mul_b = h3;     end
            ST_H3: begin mul_a = rc_reg; mul_b = rs_reg; end
            ST_H4: begin mul_a = rc_reg; mul_b = h2;     end
            ST_H5: begin mul_a = rb_reg; mul_b = rc_reg; end
            ST_H6: begin mul_a = {32'b0, s32}; mul_b = {32'b0, s32}; end
            ST_H7: begin mul_a = rc_reg; mul_b = h1;     end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Sequence the formulas
    always_comb
    begin
        phase_next        = phase_reg;
        step_next         = step_reg;
        item_next         = item_reg;
        wide_next         = wide_reg;
        rt_next           = rt_reg;
        ra_next           = ra_reg;
        rb_next           = rb_reg;
        rc_next           = rc_reg;
        rs_next           = rs_reg;
        rp_next           = rp_reg;
        temp_next         = temp_reg;
        press_next        = press_reg;
        zero_next         = zero_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mul_start         = 1'b0;
        div_start         = 1'b0;
        pop               = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                // Take the next queued reading
                if (head.valid)
                begin
                    pop        = 1'b1;
                    item_next  = head.sample;
                    wide_next  = head.wide_path;
                    zero_next  = 1'b0;
                    step_next  = ST_T0;
                    phase_next = PH_ISSUE;
                end
            end
            PH_ISSUE:
            begin
                priority if (step_reg == ST_PF)
                begin
                    press_next = pf64[31:0];
                    step_next  = ST_H0;
                end
                else if (step_reg == ST_QF)
                begin
                    press_next = {qf32[23:0], 8'b0};
                    step_next  = ST_H0;
                end
                else if (step_reg == ST_DV)
                begin
                    div_start  = 1'b1;
                    phase_next = PH_DIVW;
                end
                else
                begin
                    mul_start  = 1'b1;
                    phase_next = PH_MULW;
                end
            end
            PH_DIVW:
            begin
                // Hold until the quotient is ready
                if (div_done)
                begin
                    if (wide_reg)
                    begin
                        rp_next   = div_q;
                        step_next = ST_P7;
                    end
                    else
                    begin
                        rp_next   = rc_reg[31] ? {32'b0, div_q[30:0], 1'b0}
                                               : {32'b0, div_q[31:0]};
                        step_next = ST_Q7;
                    end
                    phase_next = PH_ISSUE;
                end
            end
            PH_MULW:
            begin
                if (mul_done)
                begin
                    phase_next = PH_ISSUE;
                    step_next  = step_reg + 1'b1;
                    unique case (step_reg)
                        ST_T0: ra_next = thp_pkg::asr64(mul_p, 11);
                        ST_T1: rb_next = thp_pkg::asr64(mul_p, 12);
                        ST_T2: rt_next = ra_reg + thp_pkg::asr64(mul_p, 14);
                        ST_T3:
                        begin
                            temp_next = temp_sat;
                            step_next = wide_reg ? ST_P0 : ST_Q0;
                        end
                        ST_P0: begin ra_next = a64; rs_next = mul_p; end
                        ST_P1: rb_next = mul_p;
                        ST_P2: rb_next = rb_reg + (mul_p << 17) + (p4 << 35);
                        ST_P3: rc_next = thp_pkg::asr64(mul_p, 8);
                        ST_P4: rc_next = rc_reg + (mul_p << 12);
                        ST_P5:
                        begin
                            ra_next = a_new64;
                            if (a_new64 == '0)
                            begin
                                zero_next  = 1'b1;
                                press_next = '0;
                                step_next  = ST_H0;
                            end
                        end
                        ST_P6: begin rc_next = mul_p; step_next = ST_DV; end
                        ST_P7: rs_next = mul_p;
                        ST_P8: ra_next = thp_pkg::asr64(mul_p, 25);
                        ST_P9: rb_next = thp_pkg::asr64(mul_p, 19);
                        ST_Q0: begin ra_next = {32'b0, a32}; rs_next = {32'b0, pr32}; end
                        ST_Q1: rb_next = {32'b0, pr32};
                        ST_Q2:
                        begin
                            rb_next = {32'b0, thp_pkg::asr32(rb_reg[31:0] + (pr32 << 1), 2)
                                              + (p4[31:0] << 16)};
                        end
                        ST_Q3: rc_next = {32'b0, thp_pkg::asr32(pr32, 3)};
                        ST_Q4:
                        begin
                            rc_next = {32'b0, thp_pkg::asr32(rc_reg[31:0]
                                              + thp_pkg::asr32(pr32, 1), 18)};
                        end
                        ST_Q5:
                        begin
                            ra_next = {32'b0, a_new32};
                            if (a_new32 == '0)
                            begin
                                zero_next  = 1'b1;
                                press_next = '0;
                                step_next  = ST_H0;
                            end
                        end
                        ST_Q6: begin rc_next = {32'b0, pr32}; step_next = ST_DV; end
                        ST_Q7: rs_next = {32'b0, pr32 >> 13};
                        ST_Q8: ra_next = {32'b0, thp_pkg::asr32(pr32, 12)};
                        ST_Q9:
                        begin
                            rb_next   = {32'b0, thp_pkg::asr32(pr32, 13)};
                            step_next = ST_QF;
                        end
                        ST_H0:
                        begin
                            ra_next = {32'b0, v32h};
                            rb_next = {32'b0, thp_pkg::asr32(({16'b0, item_reg.raw_humidity} << 14)
                                      - (h4[31:0] << 20) - pr32 + 32'd16384, 15)};
                        end
                        ST_H1: rc_next = {32'b0, thp_pkg::asr32(pr32, 10)};
                        ST_H2: rs_next = {32'b0, thp_pkg::asr32(pr32, 11) + 32'd32768};
                        ST_H3: rc_next = {32'b0, thp_pkg::asr32(pr32, 10) + 32'd2097152};
                        ST_H4: rc_next = {32'b0, thp_pkg::asr32(pr32 + 32'd8192, 14)};
                        ST_H5: ra_next = {32'b0, pr32};
                        ST_H6: rc_next = {32'b0, thp_pkg::asr32(pr32, 7)};
                        ST_H7:
                        begin
                            // Issue the result transfer
                            result_next.temperature_centi     = temp_reg;
                            result_next.pressure_q24_8        = press_reg;
                            result_next.humidity_q22_10       = hcl32[28:12];
                            result_next.pressure_divisor_zero = zero_reg;
                            result_valid_next                 = 1'b1;
                            phase_next                        = PH_IDLE;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        item_reg   <= item_next;
        wide_reg   <= wide_next;
        rt_reg     <= rt_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rc_reg     <= rc_next;
        rs_reg     <= rs_next;
        rp_reg     <= rp_next;
        temp_reg   <= temp_next;
        press_reg  <= press_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    thp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    thp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ra_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held for more than one cycle");

    a_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.pressure_divisor_zero)
        |-> result_reg.pressure_q24_8 == '0)
        else $error("zero divisor flagged with non-zero pressure");

    a_humidity_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.humidity_q22_10 <= 17'd102400)
        else $error("humidity above full scale");

    a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> ##4 mul_done)
        else $error("multiplier result late");

endmodule

`default_nettype wire

// ----- design/thp_sensor_compensation.sv -----
// ---------------------------------------------------------------------------
// thp_sensor_compensation : temperature, pressure and humidity compensation
// Integer compensation of raw sensor readings with programmable calibration.
// ---------------------------------------------------------------------------
// A reading is taken on any clock edge with start high and busy low; up to
// four readings wait in an input queue, so busy rises only when that queue is
// full. Each reading yields one result, shown for a single cycle with
// result_valid high; the receiver must take it then. Readings are worked one
// at a time on a shared multiplier (up to 22 products per reading) and a
// one-bit-per-cycle 64-bit divider. Results leave in the order readings
// arrived. The configuration port is always ready; write calibration only
// while no reading is queued or in progress.
`default_nettype none

module thp_sensor_compensation (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire thp_pkg::sample_t                   sample,
    output logic                                    result_valid,
    output thp_pkg::result_t                        result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [thp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [thp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    thp_pkg::cal_t        cal_reg, cal_next;
    thp_pkg::queue_head_t head;
    logic                 pop;

    assign cfg_ready = 1'b1;

    // Decode register writes; drop unknown indexes
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                thp_pkg::CFG_CAL_TEMP:         cal_next.cal_temp         = cfg_data;
                thp_pkg::CFG_CAL_PRESS_FIRST:  cal_next.cal_press_first  = cfg_data;
                thp_pkg::CFG_CAL_PRESS_MIDDLE: cal_next.cal_press_middle = cfg_data;
                thp_pkg::CFG_CAL_PRESS_LAST:   cal_next.cal_press_last   = cfg_data;
                thp_pkg::CFG_CAL_HUM_FIRST:    cal_next.cal_hum_first    = cfg_data[31:0];
                thp_pkg::CFG_CAL_HUM_LAST:     cal_next.cal_hum_last     = cfg_data[31:0];
                thp_pkg::CFG_PRESS_PRECISION:  cal_next.pressure_precision = cfg_data[0];
                default:                       cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '{cal_temp: 48'd0, cal_press_first: 48'd0, cal_press_middle: 48'd0,
                         cal_press_last: 48'd0, cal_hum_first: 32'd0, cal_hum_last: 32'd0,
                         pressure_precision: 1'b1};
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    thp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .wide_path (cal_reg.pressure_precision),
        .pop       (pop),
        .head      (head)
    );

    thp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cal          (cal_reg),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top : testbench for thp_sensor_compensation
// Drives raw readings through the command port and writes calibration
// between phases. Every result is checked field by field against a local
// integer model of the compensation formulas, or against a typed value.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import thp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 250;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    // Calibration sets applied before a group of readings
    typedef enum int {SETUP_NONE, SETUP_ZERO_NARROW, SETUP_DATASHEET_WIDE,
                      SETUP_DATASHEET_NARROW, SETUP_ONES_WIDE} setup_t;

    typedef struct {
        setup_t  setup;
        sample_t reading;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    sample_t                sample = '0;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Typed expectation travels with the reading
    logic                   row_typed = 1'b0;
    result_t                row_want = '0;

    logic [47:0]            cal_regs [7];
    result_t                pending_results [$];
    stim_row_t              stim_table [$];
    int                     errors = 0;
    int                     idle_pct = 0;
    int                     quiet_cycles = 0;

    thp_sensor_compensation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Arithmetic shift right of a 64-bit word
    function automatic logic [63:0] shr64(input logic [63:0] v, input int n);
        logic [127:0] w;
        w = {{64{v[63]}}, v} >> n;
        return w[63:0];
    endfunction

    function automatic logic [31:0] shr32(input logic [31:0] v, input int n);
        logic [63:0] w;
        w = {{32{v[31]}}, v} >> n;
        return w[31:0];
    endfunction

    // Sign-extend the low bits of v
    function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
        return shr64(v << (64 - bits), 64 - bits);
    endfunction

    function automatic logic [63:0] cal_field(input int r, input int lo, input int bits,
                                              input bit sgn);
        logic [63:0] v;
        v = ({16'd0, cal_regs[r]} >> lo) & ((64'd1 << bits) - 64'd1);
        return sgn ? sext(v, bits) : v;
    endfunction

    // Signed 64-bit division, truncating, with wrap on overflow
    function automatic logic [63:0] div_s64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] pressure_wide(input logic [63:0] tf, input logic [63:0] up,
                                                  output bit zero);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p;
        p1 = cal_field(CFG_CAL_PRESS_FIRST, 0, 16, 0);
        p2 = cal_field(CFG_CAL_PRESS_FIRST, 16, 16, 1);
        p3 = cal_field(CFG_CAL_PRESS_FIRST, 32, 16, 1);
        p4 = cal_field(CFG_CAL_PRESS_MIDDLE, 0, 16, 1);
        p5 = cal_field(CFG_CAL_PRESS_MIDDLE, 16, 16, 1);
        p6 = cal_field(CFG_CAL_PRESS_MIDDLE, 32, 16, 1);
        p7 = cal_field(CFG_CAL_PRESS_LAST, 0, 16, 1);
        p8 = cal_field(CFG_CAL_PRESS_LAST, 16, 16, 1);
        p9 = cal_field(CFG_CAL_PRESS_LAST, 32, 16, 1);
        zero = 0;
        a = tf - 64'd128000;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        a = shr64(a * a * p3, 8) + ((a * p2) << 12);
        a = shr64(((64'd1 << 47) + a) * p1, 33);
        if (a == 64'd0)
        begin
            zero = 1;
            return 32'd0;
        end
        p = 64'd1048576 - up;
        p = div_s64(((p << 31) - b) * 64'd3125, a);
        a = shr64(p9 * shr64(p, 13) * shr64(p, 13), 25);
        b = shr64(p8 * p, 19);
        p = shr64(p + a + b, 8) + (p7 << 4);
        return p[31:0];
    endfunction

    function automatic logic [31:0] pressure_narrow(input logic [31:0] tf, input logic [31:0] up,
                                                    output bit zero);
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, q, sq, p;
        p1 = 32'(cal_field(CFG_CAL_PRESS_FIRST, 0, 16, 0));
        p2 = 32'(cal_field(CFG_CAL_PRESS_FIRST, 16, 16, 1));
        p3 = 32'(cal_field(CFG_CAL_PRESS_FIRST, 32, 16, 1));
        p4 = 32'(cal_field(CFG_CAL_PRESS_MIDDLE, 0, 16, 1));
        p5 = 32'(cal_field(CFG_CAL_PRESS_MIDDLE, 16, 16, 1));
        p6 = 32'(cal_field(CFG_CAL_PRESS_MIDDLE, 32, 16, 1));
        p7 = 32'(cal_field(CFG_CAL_PRESS_LAST, 0, 16, 1));
        p8 = 32'(cal_field(CFG_CAL_PRESS_LAST, 16, 16, 1));
        p9 = 32'(cal_field(CFG_CAL_PRESS_LAST, 32, 16, 1));
        zero = 0;
        a  = shr32(tf, 1) - 32'd64000;
        q  = shr32(a, 2);
        sq = q * q;
        b  = shr32(sq, 11) * p6;
        b  = b + ((a * p5) << 1);
        b  = shr32(b, 2) + (p4 << 16);
        a  = shr32(shr32(p3 * shr32(sq, 13), 3) + shr32(p2 * a, 1), 18);
        a  = shr32((32'd32768 + a) * p1, 15);
        if (a == 32'd0)
        begin
            zero = 1;
            return 32'd0;
        end
        p = (32'd1048576 - up - shr32(b, 12)) * 32'd3125;
        if (p < 32'h80000000)
            p = (p << 1) / a;
        else
            p = (p / a) << 1;
        a = shr32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
        b = shr32((p >> 2) * p8, 13);
        p = p + shr32(a + b + p7, 4);
        return p << 8;
    endfunction

    function automatic logic [16:0] humidity_of(input logic [31:0] tf, input logic [31:0] uh);
        logic [31:0] h1, h2, h3, h4, h5, h6, v, t1, t2, s;
        h1 = 32'(cal_field(CFG_CAL_HUM_FIRST, 0, 8, 0));
        h2 = 32'(cal_field(CFG_CAL_HUM_FIRST, 8, 16, 1));
        h3 = 32'(cal_field(CFG_CAL_HUM_FIRST, 24, 8, 0));
        h4 = 32'(cal_field(CFG_CAL_HUM_LAST, 0, 12, 1));
        h5 = 32'(cal_field(CFG_CAL_HUM_LAST, 12, 12, 1));
        h6 = 32'(cal_field(CFG_CAL_HUM_LAST, 24, 8, 1));
        v  = tf - 32'd76800;
        t1 = shr32((uh << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
        t2 = shr32(shr32(v * h6, 10) * (shr32(v * h3, 11) + 32'd32768), 10) + 32'd2097152;
        t2 = shr32(t2 * h2 + 32'd8192, 14);
        v  = t1 * t2;
        s  = shr32(v, 15);
        v  = v - shr32(shr32(s * s, 7) * h1, 4);
        if (v[31])
            v = 32'd0;
        if (v > 32'd419430400)
            v = 32'd419430400;
        return 17'(v >> 12);
    endfunction

    // Compensate one reading with the current calibration
    function automatic result_t compensate(input sample_t s);
        logic [63:0] ut, t1, t2, t3, d, tf, tc;
        logic [31:0] pr;
        bit          zero;
        result_t     r;
        ut = 64'(s.raw_temperature);
        t1 = cal_field(CFG_CAL_TEMP, 0, 16, 0);
        t2 = cal_field(CFG_CAL_TEMP, 16, 16, 1);
        t3 = cal_field(CFG_CAL_TEMP, 32, 16, 1);
        tf = shr64(((ut >> 3) - (t1 << 1)) * t2, 11);
        d  = (ut >> 4) - t1;
        tf = tf + shr64(shr64(d * d, 12) * t3, 14);
        tc = shr64(tf * 64'd5 + 64'd128, 8);
        if ($signed(tc) > 64'sd8388607)
            tc = 64'd8388607;
        else if ($signed(tc) < -64'sd8388608)
            tc = -64'd8388608;
        if (cal_regs[CFG_PRESS_PRECISION][0])
            pr = pressure_wide(tf, 64'(s.raw_pressure), zero);
        else
            pr = pressure_narrow(tf[31:0], 32'(s.raw_pressure), zero);
        r.temperature_centi     = tc[23:0];
        r.pressure_q24_8        = pr;
        r.humidity_q22_10       = humidity_of(tf[31:0], 32'(s.raw_humidity));
        r.pressure_divisor_zero = zero;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Track calibration writes, accepted readings and results
    always @(posedge clk)
    begin
        result_t want;
        if (cfg_valid && cfg_ready && cfg_index != CFG_UNUSED_INDEX)
        begin
            if (cfg_index == CFG_PRESS_PRECISION)
                cal_regs[cfg_index] <= {47'd0, cfg_data[0]};
            else if (cfg_index == CFG_CAL_HUM_FIRST || cfg_index == CFG_CAL_HUM_LAST)
                cal_regs[cfg_index] <= {16'd0, cfg_data[31:0]};
            else
                cal_regs[cfg_index] <= cfg_data;
        end
        if (start && !busy)
            pending_results.push_back(row_typed ? row_want : compensate(sample));
        if (result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", 64'(result.pressure_q24_8),
                                64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                    report_mismatch("temperature_centi", 64'(result.temperature_centi),
                                    64'(want.temperature_centi));
                if (result.pressure_q24_8 !== want.pressure_q24_8)
                    report_mismatch("pressure_q24_8", 64'(result.pressure_q24_8),
                                    64'(want.pressure_q24_8));
                if (result.humidity_q22_10 !== want.humidity_q22_10)
                    report_mismatch("humidity_q22_10", 64'(result.humidity_q22_10),
                                    64'(want.humidity_q22_10));
                if (result.pressure_divisor_zero !== want.pressure_divisor_zero)
                    report_mismatch("pressure_divisor_zero", 64'(result.pressure_divisor_zero),
                                    64'(want.pressure_divisor_zero));
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Hand one reading over; start stays high for a back-to-back transfer
    task automatic send_reading(input sample_t s, input bit typed, input result_t want);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        sample    <= s;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off until every result is in, then let the block settle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_calibration(input logic [47:0] ct, input logic [47:0] pf,
                                    input logic [47:0] pm, input logic [47:0] pl,
                                    input logic [31:0] hf, input logic [31:0] hl,
                                    input bit wide);
        drain_results();
        write_reg(CFG_CAL_TEMP, ct);
        write_reg(CFG_CAL_PRESS_FIRST, pf);
        write_reg(CFG_CAL_PRESS_MIDDLE, pm);
        write_reg(CFG_CAL_PRESS_LAST, pl);
        write_reg(CFG_CAL_HUM_FIRST, {16'd0, hf});
        write_reg(CFG_CAL_HUM_LAST, {16'd0, hl});
        write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
        write_reg(CFG_PRESS_PRECISION, {$urandom, 15'd0, wide});
        @(posedge clk);
    endtask

    // Typical factory calibration
    task automatic load_datasheet(input bit wide);
        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd3024, 16'hD643, 16'd36477},
                         {16'hFFF9, 16'd140, 16'd2855},
                         {16'd6000, 16'hC6F8, 16'd15500},
                         {8'd0, 16'd362, 8'd75},
                         {8'd30, 12'd0, 12'd324}, wide);
    endtask

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [19:0] rand20();
        case ($urandom_range(7))
            0: return 20'd0;
            1: return 20'hFFFFF;
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic sample_t random_reading();
        sample_t s;
        s.raw_temperature = rand20();
        s.raw_pressure    = rand20();
        s.raw_humidity    = 16'(rand20());
        return s;
    endfunction

    task automatic add_row(input setup_t setup, input logic [19:0] ut, input logic [19:0] up,
                           input logic [15:0] uh, input bit typed, input result_t want);
        stim_row_t row;
        row.setup   = setup;
        row.reading = '{raw_temperature: ut, raw_pressure: up, raw_humidity: uh};
        row.typed   = typed;
        row.want    = want;
        stim_table.push_back(row);
    endtask

    initial
    begin
        result_t   after_reset;
        stim_row_t row;
        logic [47:0] noise;

        cal_regs = '{default: 48'd0};
        cal_regs[CFG_PRESS_PRECISION] = 48'd1;
        after_reset = '{temperature_centi: 24'sd0, pressure_q24_8: 32'd0,
                        humidity_q22_10: 17'd0, pressure_divisor_zero: 1'b1};

        // Zero calibration: fine temperature 0, divisor 0, humidity 0
        add_row(SETUP_NONE, 20'd0, 20'd0, 16'd0, 1, after_reset);
        add_row(SETUP_NONE, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, after_reset);
        add_row(SETUP_NONE, 20'h55555, 20'hAAAAA, 16'h5A5A, 1, after_reset);
        add_row(SETUP_ZERO_NARROW, 20'd0, 20'hFFFFF, 16'hFFFF, 1, after_reset);
        add_row(SETUP_NONE, 20'hFFFFF, 20'd0, 16'd0, 1, after_reset);
        // Typical calibration on both pressure paths
        add_row(SETUP_DATASHEET_WIDE, 20'd519888, 20'd415148, 16'd27000, 0, after_reset);
        add_row(SETUP_NONE, 20'd0, 20'd0, 16'd0, 0, after_reset);
        add_row(SETUP_NONE, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, after_reset);
        add_row(SETUP_NONE, 20'd400000, 20'd300000, 16'd50000, 0, after_reset);
        add_row(SETUP_DATASHEET_NARROW, 20'd519888, 20'd415148, 16'd27000, 0, after_reset);
        add_row(SETUP_NONE, 20'd0, 20'd0, 16'd0, 0, after_reset);
        add_row(SETUP_NONE, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, after_reset);
        add_row(SETUP_NONE, 20'd600000, 20'd500000, 16'd10000, 0, after_reset);
        // Every coefficient at all ones: extreme wrap and saturation
        add_row(SETUP_ONES_WIDE, 20'd0, 20'd0, 16'd0, 0, after_reset);
        add_row(SETUP_NONE, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, after_reset);
        add_row(SETUP_NONE, 20'd123456, 20'd654321, 16'd32768, 0, after_reset);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (stim_table[i])
        begin
            row = stim_table[i];
            case (row.setup)
                SETUP_ZERO_NARROW:
                    load_calibration('0, '0, '0, '0, '0, '0, 0);
                SETUP_DATASHEET_WIDE:
                    load_datasheet(1);
                SETUP_DATASHEET_NARROW:
                    load_datasheet(0);
                SETUP_ONES_WIDE:
                    load_calibration('1, '1, '1, '1, '1, '1, 1);
                default:
                    ;
            endcase
            send_reading(row.reading, row.typed, row.want);
        end

        // Random readings over several calibrations and idle patterns
        for (int phase = 0; phase < 8; phase++)
        begin
            noise = rand48();
            case (phase % 4)
                0: load_datasheet(phase[2]);
                1: load_calibration(rand48(), rand48(), rand48(), rand48(),
                                    $urandom, $urandom, $urandom_range(1));
                2: load_calibration(phase[2] ? '1 : '0, rand48(), rand48(), rand48(),
                                    $urandom, $urandom, phase[2]);
                default: load_calibration({noise[47:32], 16'd26435, 16'd27504},
                                          {noise[31:16], 16'hD643, 16'd36477},
                                          rand48(), rand48(), $urandom, $urandom,
                                          !phase[2]);
            endcase
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 49;
                2: idle_pct = 13;
                default: idle_pct = 49;
            endcase
            for (int n = 0; n < 100; n++)
                send_reading(random_reading(), 0, after_reset);
        end

        drain_results();
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
